// ----- sv/dual_stepper_step_generator_assert.svh -----
// Assertion macros used by the step generator sequencer (dsg_ctrl).
// Expects signals named clk and rst (synchronous, active high) in scope.
`ifndef DUAL_STEPPER_STEP_GENERATOR_ASSERT_SVH
`define DUAL_STEPPER_STEP_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define DSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DSG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/dsg_pkg.sv -----
// Shared types, codes and constants of the dual stepper step generator.
// No dependencies.
`default_nettype none
package dsg_pkg;

  localparam int PERIOD_W  = 16;
  localparam int POS_W     = 32;
  localparam int SPEED_W   = 16;
  localparam int CFG_W     = 14;
  localparam int DIV_W     = PERIOD_W + 3;  // quotient plus three fraction bits
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int IDLE_PERIOD_DEF = 65535;
  localparam int BASE_TICKS_DEF  = 1000;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_REVERSE     = 2'd2;

  localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 14'd1000;
  localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST = 14'd8;

  typedef struct packed {
    logic [CFG_W-1:0] speed_limit;
    logic [CFG_W-1:0] accel_limit;
    logic             reverse;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic do_clamp;
    logic do_accel;
    logic do_setup;
    logic div_step;
    logic div_finish;
    logic do_tick;
    logic do_clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       speed_zero;
  } stat_t;

  // Position of a sub-period entry in the padding order 1,5,3,7,0,4,2.
  function automatic logic [2:0] pad_rank(input logic [2:0] e);
    logic [2:0] r;
    unique case (e)
      3'd1:    r = 3'd0;
      3'd5:    r = 3'd1;
      3'd3:    r = 3'd2;
      3'd7:    r = 3'd3;
      3'd0:    r = 3'd4;
      3'd4:    r = 3'd5;
      3'd2:    r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/dual_stepper_step_generator.sv -----
// Dual stepper step generator.
// Input channel (in_valid/in_stall) carries op, motor_sel, speed; one result
// per item leaves on the output channel (out_valid/out_stall) with step bits,
// direction bits, motors_enabled and both positions.
// One item is worked at a time; in_stall is high from acceptance until its
// result is loaded into the output register.
// Each item steps through the sequencer: tick, clear and unused ops go from
// dispatch straight to the result; a set speed is clamped and ramped, and if it
// ends nonzero it runs the restoring divider (one quotient bit a cycle, which
// yields sub-period and padding in one pass) before the result.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile and waits in its final state until the register frees.
// Reset (rst, synchronous) zeroes speeds, counters, sub-indices, directions
// and positions and loads the register defaults; no item is in flight.
// Configuration: APB-style, speed limit at 0x0, acceleration limit at 0x4,
// reverse_direction at 0x8; write only while idle.
// Depends on dsg_pkg, dsg_regs, dsg_ctrl, dsg_dp.
`default_nettype none
module dual_stepper_step_generator #(
  parameter int IDLE_PERIOD = dsg_pkg::IDLE_PERIOD_DEF,
  parameter int BASE_TICKS  = dsg_pkg::BASE_TICKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  op,
  input  wire logic                        motor_sel,
  input  wire logic signed [15:0]          speed,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             step_a,
  output logic                             step_b,
  output logic                             dir_a,
  output logic                             dir_b,
  output logic                             motors_enabled,
  output logic signed [dsg_pkg::POS_W-1:0] position_a,
  output logic signed [dsg_pkg::POS_W-1:0] position_b,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  dsg_pkg::cfg_t  cfg;
  dsg_pkg::cmd_t  cmd;
  dsg_pkg::stat_t stat;

  dsg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dsg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  dsg_dp #(
    .IDLE_PERIOD (IDLE_PERIOD),
    .BASE_TICKS  (BASE_TICKS)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .stat, .op, .motor_sel, .speed,
    .step_a, .step_b, .dir_a, .dir_b, .motors_enabled, .position_a, .position_b
  );

endmodule
`default_nettype wire

// ----- sv/dsg_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on dsg_pkg.
`default_nettype none
module dsg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output dsg_pkg::cfg_t    cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit <= dsg_pkg::SPEED_LIMIT_RST;
      cfg.accel_limit <= dsg_pkg::ACCEL_LIMIT_RST;
      cfg.reverse     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        dsg_pkg::REG_SPEED_LIMIT: cfg.speed_limit <= pwdata[dsg_pkg::CFG_W-1:0];
        dsg_pkg::REG_ACCEL_LIMIT: cfg.accel_limit <= pwdata[dsg_pkg::CFG_W-1:0];
        dsg_pkg::REG_REVERSE:     cfg.reverse     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dsg_pkg::REG_SPEED_LIMIT: prdata = {18'd0, cfg.speed_limit};
      dsg_pkg::REG_ACCEL_LIMIT: prdata = {18'd0, cfg.accel_limit};
      dsg_pkg::REG_REVERSE:     prdata = {31'd0, cfg.reverse};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/dsg_ctrl.sv -----
// Sequencer for one item at a time: dispatch, speed update, divide, result.
// Depends on dsg_pkg and the assertion header.
`default_nettype none
`include "dual_stepper_step_generator_assert.svh"
module dsg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire dsg_pkg::stat_t stat,
  output dsg_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ACCEL = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [dsg_pkg::DIV_CNT_W-1:0] DIV_LAST =
    dsg_pkg::DIV_CNT_W'(dsg_pkg::DIV_W - 1);

  logic [2:0]                    state, state_next;
  logic [dsg_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          dsg_pkg::OP_SET: begin
            cmd.do_clamp = 1'b1;
            state_next   = S_ACCEL;
          end
          dsg_pkg::OP_TICK: begin
            cmd.do_tick = 1'b1;
            state_next  = S_DONE;
          end
          dsg_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_next   = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ACCEL: begin
        cmd.do_accel = 1'b1;
        state_next   = S_SETUP;
      end
      S_SETUP: begin
        // a stopped motor keeps its direction and needs no periods
        if (stat.speed_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.do_setup = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) state_next = S_WB;
      end
      S_WB: begin
        cmd.div_finish = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      if (cmd.load_out)     out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
    end
  end

  `DSG_ASSERT_IMP(a_div_cnt_range, state == S_DIV, div_cnt <= DIV_LAST)
  `DSG_ASSERT_NXT(a_accept_exec, state == S_IDLE && in_valid, state == S_EXEC)
  `DSG_ASSERT_NXT(a_accel_setup, state == S_ACCEL, state == S_SETUP)
  `DSG_ASSERT_NXT(a_done_out, state == S_DONE && out_free,
                  out_valid && state == S_IDLE)

endmodule
`default_nettype wire

// ----- sv/dsg_dp.sv -----
// Datapath: motor state, speed clamp and ramp, period divider, tick logic,
// output register. Depends on dsg_pkg.
`default_nettype none
module dsg_dp #(
  parameter int IDLE_PERIOD = dsg_pkg::IDLE_PERIOD_DEF,
  parameter int BASE_TICKS  = dsg_pkg::BASE_TICKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dsg_pkg::cfg_t              cfg,
  input  wire dsg_pkg::cmd_t              cmd,
  output dsg_pkg::stat_t                  stat,
  input  wire logic [1:0]                 op,
  input  wire logic                       motor_sel,
  input  wire logic signed [15:0]         speed,
  output logic                            step_a,
  output logic                            step_b,
  output logic                            dir_a,
  output logic                            dir_b,
  output logic                            motors_enabled,
  output logic signed [dsg_pkg::POS_W-1:0] position_a,
  output logic signed [dsg_pkg::POS_W-1:0] position_b
);

  localparam int PW = dsg_pkg::PERIOD_W;
  localparam int DW = dsg_pkg::DIV_W;
  localparam int CW = dsg_pkg::CFG_W;
  localparam logic [PW-1:0] IDLE_P   = PW'(IDLE_PERIOD);
  localparam logic [DW-1:0] DIVIDEND = {PW'(BASE_TICKS), 3'b000};

  // latched item
  logic [1:0]         op_q;
  logic               sel_q;
  logic signed [15:0] req_q;
  logic signed [16:0] req_c;

  // motor state
  logic signed [15:0]               actual [2];
  logic                             dir    [2];
  logic [dsg_pkg::POS_W-1:0]        pos    [2];
  logic [PW-1:0]                    cnt    [2];
  logic [2:0]                       idx    [2];
  logic [PW-1:0]                    base   [2];
  logic [2:0]                       pad    [2];
  logic [1:0]                       step_q;

  // divider
  logic [CW-1:0] mag;
  logic [CW-1:0] rem;
  logic [DW-1:0] quo;

  // combinational helpers
  logic signed [16:0] req_x, lim_x, acc_x, act_x, diff, act_new, clamp_v;
  logic signed [15:0] act_sel;
  logic [15:0]        act_abs;
  logic [CW:0]        trial, trial_sub;
  logic               trial_ge;
  logic [PW-1:0]      period [2];
  logic [PW-1:0]      cnt_inc [2];
  logic               hit [2];

  assign stat.op         = op_q;
  assign stat.speed_zero = (actual[sel_q] == 16'sd0);

  always_comb begin
    req_x = {req_q[15], req_q};
    lim_x = {3'b000, cfg.speed_limit};
    if (req_x > lim_x)       clamp_v = lim_x;
    else if (req_x < -lim_x) clamp_v = -lim_x;
    else                     clamp_v = req_x;

    act_sel = actual[sel_q];
    act_x   = {act_sel[15], act_sel};
    acc_x   = {3'b000, cfg.accel_limit};
    diff    = req_c - act_x;
    if (diff > acc_x)       act_new = act_x + acc_x;
    else if (diff < -acc_x) act_new = act_x - acc_x;
    else                    act_new = req_c;

    act_abs = act_sel[15] ? 16'(-act_sel) : act_sel;

    trial     = {rem, quo[DW-1]};
    trial_ge  = (trial >= {1'b0, mag});
    trial_sub = trial - {1'b0, mag};
  end

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      if (actual[m] == 16'sd0) period[m] = IDLE_P;
      else period[m] = base[m] + PW'(dsg_pkg::pad_rank(idx[m]) < pad[m]);
      cnt_inc[m] = cnt[m] + 1'b1;
      hit[m]     = !(cnt_inc[m] < period[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= op;
      sel_q <= motor_sel;
      req_q <= speed;
    end
    if (cmd.do_clamp) req_c <= clamp_v;
    if (cmd.do_setup) begin
      mag <= act_abs[CW-1:0];
      rem <= '0;
      quo <= DIVIDEND;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      quo <= {quo[DW-2:0], trial_ge};
    end
    if (cmd.div_finish) begin
      base[sel_q] <= quo[DW-1:3];
      pad[sel_q]  <= quo[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < 2; m++) begin
        actual[m] <= '0;
        dir[m]    <= 1'b0;
        pos[m]    <= '0;
        cnt[m]    <= '0;
        idx[m]    <= '0;
      end
      step_q <= '0;
    end else begin
      if (cmd.load_item) step_q <= '0;
      if (cmd.do_accel)  actual[sel_q] <= act_new[15:0];
      // positive speed gives direction 0 unless reversed
      if (cmd.do_setup)  dir[sel_q] <= ~(~act_sel[15] ^ cfg.reverse);
      if (cmd.do_clear)  pos[sel_q] <= '0;
      if (cmd.do_tick) begin
        for (int m = 0; m < 2; m++) begin
          if (!hit[m]) begin
            cnt[m] <= cnt_inc[m];
          end else begin
            cnt[m] <= '0;
            if (actual[m] != 16'sd0) begin
              pos[m]    <= dir[m] ? pos[m] + 1'b1 : pos[m] - 1'b1;
              idx[m]    <= idx[m] + 1'b1;
              step_q[m] <= 1'b1;
            end
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_a         <= step_q[0];
      step_b         <= step_q[1];
      dir_a          <= dir[0];
      dir_b          <= dir[1];
      motors_enabled <= (actual[0] != 16'sd0) || (actual[1] != 16'sd0);
      position_a     <= pos[0];
      position_b     <= pos[1];
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for dual_stepper_step_generator: a directed table, then random phases
// per register setting, checked by a local step/position predictor or fixed row values.
// Depends on dsg_pkg and the step generator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_TICKS = dsg_pkg::IDLE_PERIOD_DEF;
  localparam int BASE = dsg_pkg::BASE_TICKS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int STEADY_PHASE = 4;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int PAD_SEQ [0:6] = '{1, 5, 3, 7, 0, 4, 2};
  localparam int PHASE_SPEED [0:N_PHASES-1] = '{1000, 16383, 0, 300, 16383, 1, 2000, 120};
  localparam int PHASE_ACCEL [0:N_PHASES-1] = '{200, 16383, 1, 1, 50, 16383, 500, 40};
  localparam int PHASE_REV [0:N_PHASES-1] = '{0, 1, 0, 1, 0, 1, 0, 1};

  typedef struct packed {
    logic step_a, step_b, dir_a, dir_b, enabled;
    logic [31:0] pos_a, pos_b;
  } motion_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         op_code;
    logic               sel;
    logic signed [15:0] spd;      // register value on register rows
    logic [1:0]         reg_idx;
    bit                 typed;
    motion_t            want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = dsg_pkg::OP_TICK;
  logic motor_sel = 1'b0;
  logic signed [15:0] speed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic step_a, step_b, dir_a, dir_b, motors_enabled;
  logic signed [dsg_pkg::POS_W-1:0] position_a, position_b;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit steady = 1'b0;
  int err_cnt = 0;
  int unsigned cycles = 0;
  motion_t expected_motion[$];

  // predictor state
  logic [15:0] cnt_q [2];
  logic [15:0] per_q [2][8];
  logic [2:0]  idx_q [2];
  int          vel_q [2];
  logic        dir_q [2];
  logic [31:0] pos_q [2];
  int          lim_speed;
  int          lim_accel;
  logic        rev_q;

  dual_stepper_step_generator #(.IDLE_PERIOD(IDLE_TICKS), .BASE_TICKS(BASE)) u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) note_error($sformatf("%s: expected %h, got %h", what, want, got));
  endfunction

  function automatic void reset_axes();
    for (int m = 0; m < 2; m++) begin
      cnt_q[m] = '0;
      idx_q[m] = '0;
      vel_q[m] = 0;
      dir_q[m] = 1'b0;
      pos_q[m] = '0;
      for (int i = 0; i < 8; i++) per_q[m][i] = 16'(IDLE_TICKS);
    end
    lim_speed = dsg_pkg::SPEED_LIMIT_RST;
    lim_accel = dsg_pkg::ACCEL_LIMIT_RST;
    rev_q = 1'b0;
  endfunction

  function automatic void rebuild_periods(int m);
    int mag, base, pad;
    if (vel_q[m] == 0) begin
      for (int i = 0; i < 8; i++) per_q[m][i] = 16'(IDLE_TICKS);
      return;
    end
    dir_q[m] = rev_q ? (vel_q[m] > 0) : (vel_q[m] <= 0);
    mag = vel_q[m] < 0 ? -vel_q[m] : vel_q[m];
    base = BASE / mag;
    // remainder spread in eighths over the padding order
    pad = ((BASE % mag) * 8) / mag;
    for (int i = 0; i < 8; i++) per_q[m][i] = 16'(base);
    for (int i = 0; i < 7 && i < pad; i++) per_q[m][PAD_SEQ[i]] = 16'(base + 1);
  endfunction

  function automatic void command_speed(int m, int req);
    int target, delta;
    target = req;
    if (target > lim_speed) target = lim_speed;
    if (target < -lim_speed) target = -lim_speed;
    delta = target - vel_q[m];
    if (delta > lim_accel) vel_q[m] += lim_accel;
    else if (delta < -lim_accel) vel_q[m] -= lim_accel;
    else vel_q[m] = target;
    rebuild_periods(m);
  endfunction

  function automatic logic tick_axis(int m);
    cnt_q[m] = cnt_q[m] + 16'd1;
    if (cnt_q[m] < per_q[m][idx_q[m]]) return 1'b0;
    cnt_q[m] = '0;
    if (vel_q[m] == 0) return 1'b0;
    pos_q[m] = dir_q[m] ? pos_q[m] + 32'd1 : pos_q[m] - 32'd1;
    idx_q[m] = idx_q[m] + 3'd1;
    return 1'b1;
  endfunction

  function automatic motion_t advance_axes(logic [1:0] op_code, logic sel,
                                           logic signed [15:0] spd);
    motion_t r;
    r = '0;
    case (op_code)
      dsg_pkg::OP_SET: command_speed(int'(sel), int'(spd));
      dsg_pkg::OP_TICK: begin
        r.step_a = tick_axis(0);
        r.step_b = tick_axis(1);
      end
      dsg_pkg::OP_CLEAR: pos_q[sel] = '0;
      default: ;
    endcase
    r.dir_a = dir_q[0];
    r.dir_b = dir_q[1];
    r.enabled = (vel_q[0] != 0) || (vel_q[1] != 0);
    r.pos_a = pos_q[0];
    r.pos_b = pos_q[1];
    return r;
  endfunction

  function automatic row_t item_row(logic [1:0] op_code, logic sel, logic signed [15:0] spd);
    row_t r;
    r.kind = ROW_ITEM;
    r.op_code = op_code;
    r.sel = sel;
    r.spd = spd;
    r.reg_idx = dsg_pkg::REG_SPEED_LIMIT;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // flags = {step_a, step_b, dir_a, dir_b, enabled}; both positions still zero
  function automatic row_t typed_row(logic [1:0] op_code, logic sel, logic signed [15:0] spd,
                                     logic [4:0] flags);
    row_t r;
    r = item_row(op_code, sel, spd);
    r.typed = 1'b1;
    r.want = {flags, 64'd0};
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [13:0] value);
    row_t r;
    r = item_row(dsg_pkg::OP_TICK, 1'b0, 16'(value));
    r.kind = ROW_REG;
    r.reg_idx = idx;
    return r;
  endfunction

  task automatic send_item(logic [1:0] op_code, logic sel, logic signed [15:0] spd,
                           bit typed, motion_t want);
    motion_t got;
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_code;
    motor_sel <= sel;
    speed <= spd;
    do @(posedge clk); while (in_stall);
    got = advance_axes(op_code, sel, spd);
    expected_motion.push_back(typed ? want : got);
  endtask

  // hold the sender until every outstanding result has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  // write, then read back the same register in a back-to-back transfer
  task automatic write_register(logic [1:0] idx, logic [13:0] value);
    logic [31:0] back;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dsg_pkg::REG_SPEED_LIMIT: lim_speed = value;
      dsg_pkg::REG_ACCEL_LIMIT: lim_accel = value;
      dsg_pkg::REG_REVERSE:     rev_q = value[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      back = prdata;
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_field($sformatf("register %0d readback", idx), 32'(value), back);
  endtask

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 34);

  always @(posedge clk) begin
    motion_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_motion.size() == 0) begin
        note_error("result transfer with nothing expected");
      end else begin
        want = expected_motion.pop_front();
        check_field("step_a", 32'(want.step_a), 32'(step_a));
        check_field("step_b", 32'(want.step_b), 32'(step_b));
        check_field("dir_a", 32'(want.dir_a), 32'(dir_a));
        check_field("dir_b", 32'(want.dir_b), 32'(dir_b));
        check_field("motors_enabled", 32'(want.enabled), 32'(motors_enabled));
        check_field("position_a", want.pos_a, position_a);
        check_field("position_b", want.pos_b, position_b);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int pick, span;
    logic [1:0] op_code;
    logic sel;
    logic signed [15:0] spd;

    reset_axes();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(typed_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0, 5'b00000));
    rows.push_back(typed_row(OP_UNUSED, 1'b1, 16'sh7fff, 5'b00000));
    rows.push_back(typed_row(dsg_pkg::OP_CLEAR, 1'b1, 16'sh8000, 5'b00000));
    // clamped to the speed limit, then held to +/- the acceleration limit
    rows.push_back(typed_row(dsg_pkg::OP_SET, 1'b0, 16'sh7fff, 5'b00001));
    rows.push_back(typed_row(dsg_pkg::OP_SET, 1'b1, 16'sh8000, 5'b00011));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(reg_row(dsg_pkg::REG_SPEED_LIMIT, 14'h3fff));
    rows.push_back(reg_row(dsg_pkg::REG_ACCEL_LIMIT, 14'h3fff));
    // above base ticks: zero sub-period, steps on every tick
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b0, 16'sh7fff));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b1, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b1, 16'sd1));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b1, -16'sd3));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    // 143 pads all seven entries
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b1, 16'sd143));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    // stop keeps the direction bit
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b0, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_CLEAR, 1'b1, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_CLEAR, 1'b0, 16'sd0));
    rows.push_back(reg_row(dsg_pkg::REG_REVERSE, 14'd1));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b0, 16'sh8000));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b1, 16'sd300));
    rows.push_back(item_row(dsg_pkg::OP_TICK, 1'b0, 16'sd0));
    rows.push_back(reg_row(dsg_pkg::REG_ACCEL_LIMIT, 14'd1));
    rows.push_back(reg_row(dsg_pkg::REG_SPEED_LIMIT, 14'd0));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b0, 16'sd5));
    rows.push_back(item_row(dsg_pkg::OP_SET, 1'b1, -16'sd7));
    rows.push_back(item_row(OP_UNUSED, 1'b1, -16'sd1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        drain();
        write_register(rows[i].reg_idx, rows[i].spd[13:0]);
      end else begin
        send_item(rows[i].op_code, rows[i].sel, rows[i].spd, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_register(dsg_pkg::REG_SPEED_LIMIT, 14'(PHASE_SPEED[p]));
      write_register(dsg_pkg::REG_ACCEL_LIMIT, 14'(PHASE_ACCEL[p]));
      write_register(dsg_pkg::REG_REVERSE, 14'(PHASE_REV[p]));
      steady = (p == STEADY_PHASE);
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 58) op_code = dsg_pkg::OP_TICK;
        else if (pick < 86) op_code = dsg_pkg::OP_SET;
        else if (pick < 94) op_code = dsg_pkg::OP_CLEAR;
        else op_code = OP_UNUSED;
        sel = 1'($urandom_range(1));
        span = lim_speed + lim_speed / 4 + 2;
        pick = $urandom_range(99);
        if (pick < 50) spd = 16'(int'($urandom_range(2 * span)) - span);
        else if (pick < 70) spd = 16'($urandom);
        else if (pick < 78) spd = '0;
        else if (pick < 90) spd = 16'(int'($urandom_range(40)) - 20);
        else spd = pick[0] ? 16'sh7fff : 16'sh8000;
        send_item(op_code, sel, spd, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/dsg_pkg.sv
sv/dsg_regs.sv
sv/dsg_ctrl.sv
sv/dsg_dp.sv
sv/dual_stepper_step_generator.sv
bench/tb_top.sv
